/* sv/hexmix_pkg.sv */
`default_nettype none
package hexmix_pkg;

  // array sizes
  localparam int NUM_MOTORS = 6;
  localparam int NUM_AXES   = 4;
  localparam int OUT_FIELDS = 6;

  localparam int MOT_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int AX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // field widths
  localparam int VAL_W     = 16;
  localparam int CMD_W     = 12;
  localparam int CFG_IDX_W = 4;

  // arithmetic widths: Q2.14 x Q2.14 products, summed, scaled by 1000, floored
  localparam int FRAC_BITS   = 28;
  localparam int SCALE_SHIFT = 10;
  localparam int MUL_W       = 2 * VAL_W;
  localparam int ACC_W       = MUL_W + $clog2(NUM_AXES);
  localparam int SCL_W       = ACC_W + SCALE_SHIFT;
  localparam int RES_W       = SCL_W - FRAC_BITS;
  localparam int CMP_W       = RES_W + 1;

  // constants
  localparam int CMD_OFFSET   = 1000;
  localparam int ARMED_OFFSET = 150;
  localparam int CMD_MAX      = 4095;
  localparam int ESC_MIN_RST  = 1000;
  localparam int ESC_MAX_RST  = 2000;

  // item codes
  localparam logic [1:0] MODE_AXIS = 2'd0;
  localparam logic [1:0] MODE_ARM  = 2'd1;
  localparam logic [1:0] MODE_COEF = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ESC_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ESC_MAX = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]              mode;
    logic [2:0]              axis;
    logic signed [VAL_W-1:0] value;
    logic [2:0]              motor;
    logic                    arm;
  } in_item_t;

  typedef struct packed {
    logic [CMD_W-1:0] motor_cmd_0;
    logic [CMD_W-1:0] motor_cmd_1;
    logic [CMD_W-1:0] motor_cmd_2;
    logic [CMD_W-1:0] motor_cmd_3;
    logic [CMD_W-1:0] motor_cmd_4;
    logic [CMD_W-1:0] motor_cmd_5;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             mac_en;
    logic             first;
    logic             last;
    logic [MOT_W-1:0] mot;
    logic [AX_W-1:0]  ax;
    logic             push;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

/* sv/hexa_motor_mixer_core.sv */
`default_nettype none
// Hexacopter motor mixer.
// Axis update: the result is valid once every motor's sum has passed the pipeline;
// one shared multiply-accumulate takes one table product per cycle, and no new
// item is taken until that update is pushed. Arm and table writes give no result.
// A finished result waits in the output register while the next item is taken.
// Sync reset (rst_n low): demands, table cleared, disarmed, esc_min 1000, esc_max 2000.
module hexa_motor_mixer_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire hexmix_pkg::in_item_t         in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output hexmix_pkg::out_item_t             out_item,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [hexmix_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hexmix_pkg::CMD_W-1:0]     cfg_data
);
  import hexmix_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // registers always take a write
  assign cfg_ready = 1'b1;

  hexmix_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hexmix_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

/* sv/hexmix_ctrl.sv */
`default_nettype none
module hexmix_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [1:0]            in_mode,
  output logic                       in_ready,
  input  wire hexmix_pkg::dp_sts_t   sts,
  output hexmix_pkg::ctrl_cmd_t      cmd
);
  import hexmix_pkg::*;

  localparam logic [MOT_W-1:0] LAST_MOT = MOT_W'(NUM_MOTORS - 1);
  localparam logic [AX_W-1:0]  LAST_AX  = AX_W'(NUM_AXES - 1);

  state_t           state_r, state_nxt;
  logic [MOT_W-1:0] mot_r, mot_nxt;
  logic [AX_W-1:0]  ax_r, ax_nxt;

  // state and step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mot_r   <= '0;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      mot_r   <= mot_nxt;
      ax_r    <= ax_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    mot_nxt    = mot_r;
    ax_nxt     = ax_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.mac_en = 1'b0;
    cmd.first  = (ax_r == '0);
    cmd.last   = (ax_r == LAST_AX);
    cmd.mot    = mot_r;
    cmd.ax     = ax_r;
    cmd.push   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        mot_nxt  = '0;
        ax_nxt   = '0;
        if (in_valid && in_mode == MODE_AXIS) begin
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        // one product per cycle, motor by motor
        cmd.mac_en = 1'b1;
        if (ax_r == LAST_AX) begin
          ax_nxt = '0;
          if (mot_r == LAST_MOT) begin
            mot_nxt   = '0;
            state_nxt = S_DRAIN;
          end else begin
            mot_nxt = mot_r + 1'b1;
          end
        end else begin
          ax_nxt = ax_r + 1'b1;
        end
      end
      S_DRAIN: begin
        // wait for the pipeline to empty and the output slot to free
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_mac_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_MAC) |-> (mot_r == '0 && ax_r == '0))
    else $error("mix sequence did not start at first entry");

  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.pipe_busy)
    else $error("result pushed while pipeline busy");

  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> (state_r == S_IDLE))
    else $error("controller not idle after push");

endmodule
`default_nettype wire

/* sv/hexmix_dp.sv */
`default_nettype none
module hexmix_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire hexmix_pkg::in_item_t   in_item,
  input  wire logic                   cfg_valid,
  input  wire logic [hexmix_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hexmix_pkg::CMD_W-1:0]     cfg_data,
  input  wire hexmix_pkg::ctrl_cmd_t  cmd,
  output hexmix_pkg::dp_sts_t         sts,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output hexmix_pkg::out_item_t       out_item
);
  import hexmix_pkg::*;

  // configuration and item state
  logic [CMD_W-1:0]        esc_min_r, esc_max_r;
  logic                    armed_r;
  logic signed [VAL_W-1:0] dem_r  [NUM_AXES];
  logic signed [VAL_W-1:0] coef_r [NUM_MOTORS][NUM_AXES];

  // mixing pipeline
  logic signed [MUL_W-1:0] prod_r;
  logic                    s1_vld_r, s1_first_r, s1_last_r;
  logic [MOT_W-1:0]        s1_mot_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    s2_last_r;
  logic [MOT_W-1:0]        s2_mot_r;
  logic signed [RES_W-1:0] res_r;
  logic                    s3_last_r;
  logic [MOT_W-1:0]        s3_mot_r;
  logic [CMD_W-1:0]        cmd_r [NUM_MOTORS];

  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic                    ax_ok, mot_ok;
  logic signed [SCL_W-1:0] acc_x, scaled;
  logic signed [CMP_W-1:0] v, lo, hi, clamped;
  logic [CMD_W-1:0]        cmd_val;
  logic [CMD_W-1:0]        cmd_full [OUT_FIELDS];

  assign ax_ok  = int'(in_item.axis) < NUM_AXES;
  assign mot_ok = int'(in_item.motor) < NUM_MOTORS;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_min_r <= CMD_W'(ESC_MIN_RST);
      esc_max_r <= CMD_W'(ESC_MAX_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ESC_MIN: esc_min_r <= cfg_data;
        REG_ESC_MAX: esc_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // item effects: arm flag, table write, demand update (all demands cleared while disarmed)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        dem_r[a] <= '0;
        for (int m = 0; m < NUM_MOTORS; m++) begin
          coef_r[m][a] <= '0;
        end
      end
    end else if (cmd.load) begin
      case (in_item.mode)
        MODE_ARM: armed_r <= in_item.arm;
        MODE_COEF: begin
          if (ax_ok && mot_ok) begin
            coef_r[in_item.motor[MOT_W-1:0]][in_item.axis[AX_W-1:0]] <= in_item.value;
          end
        end
        MODE_AXIS: begin
          if (armed_r) begin
            if (ax_ok) begin
              dem_r[in_item.axis[AX_W-1:0]] <= in_item.value;
            end
          end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
              dem_r[a] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // stage 1: one product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.mac_en;
    end
    s1_first_r <= cmd.first;
    s1_last_r  <= cmd.last;
    s1_mot_r   <= cmd.mot;
    prod_r     <= coef_r[cmd.mot][cmd.ax] * dem_r[cmd.ax];
  end

  // stage 2: accumulate over the axes of one motor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_last_r <= 1'b0;
    end else begin
      s2_last_r <= s1_vld_r && s1_last_r;
    end
    s2_mot_r <= s1_mot_r;
    if (s1_vld_r) begin
      if (s1_first_r) begin
        acc_r <= ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // stage 3: times 1000 as shift-and-subtract, then floor of the Q28 fraction
  assign acc_x  = SCL_W'(acc_r);
  assign scaled = (acc_x <<< SCALE_SHIFT) - (acc_x <<< 4) - (acc_x <<< 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_last_r <= 1'b0;
    end else begin
      s3_last_r <= s2_last_r;
    end
    s3_mot_r <= s2_mot_r;
    res_r    <= scaled[SCL_W-1:FRAC_BITS];
  end

  // stage 4: offset, clamp to the ESC range (minimum raised by ARMED_OFFSET when armed), saturate to the field
  assign v  = CMP_W'(res_r) + CMP_W'(CMD_OFFSET);
  assign hi = signed'(CMP_W'(esc_max_r));
  assign lo = signed'(CMP_W'(esc_min_r)) + (armed_r ? CMP_W'(ARMED_OFFSET) : '0);

  always_comb begin
    if (v > hi) begin
      clamped = hi;
    end else if (v < lo) begin
      clamped = lo;
    end else begin
      clamped = v;
    end
    if (clamped > CMP_W'(CMD_MAX)) begin
      cmd_val = CMD_W'(CMD_MAX);
    end else begin
      cmd_val = clamped[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_last_r) begin
      cmd_r[s3_mot_r] <= cmd_val;
    end
  end

  // result fields, missing motors read zero
  always_comb begin
    for (int j = 0; j < OUT_FIELDS; j++) begin
      if (j < NUM_MOTORS) begin
        cmd_full[j] = cmd_r[MOT_W'(j)];
      end else begin
        cmd_full[j] = '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.push) begin
      out_item_r.motor_cmd_0 <= cmd_full[0];
      out_item_r.motor_cmd_1 <= cmd_full[1];
      out_item_r.motor_cmd_2 <= cmd_full[2];
      out_item_r.motor_cmd_3 <= cmd_full[3];
      out_item_r.motor_cmd_4 <= cmd_full[4];
      out_item_r.motor_cmd_5 <= cmd_full[5];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;
  assign sts.pipe_busy = s1_vld_r || s2_last_r || s3_last_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_mot_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_last_r |-> (int'(s3_mot_r) < NUM_MOTORS))
    else $error("command written for missing motor");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(s1_vld_r || s2_last_r || s3_last_r))
    else $error("item taken while mixing");

endmodule
`default_nettype wire
